### hdl/fgc_pkg.sv
// ----------------------------------------------------------------------------
// fgc_pkg
// Shared types, constants and gesture tables for the face gesture classifier.
// ----------------------------------------------------------------------------
package fgc_pkg;

  localparam int NUM_MEASURES_DEF  = 8;
  localparam int NUM_GESTURES_DEF  = 11;
  localparam int MEASURE_WIDTH_DEF = 16;
  localparam int NUM_MEASURES      = 8;
  localparam int NUM_GESTURES      = 11;
  localparam int MIDX_W            = 3;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 64;
  localparam int CNT_W             = 8;

  localparam logic [CFG_IDX_W-1:0] REG_THR_HEAD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_FACE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BL_TICKS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NOFACE    = 3'd5;

  localparam int LEFT_EYE  = 6;
  localparam int RIGHT_EYE = 7;
  localparam int WINK_L    = 9;
  localparam int WINK_R    = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL,
    ST_TRACK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic eval;
    logic track;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic track_done;
  } sts_t;

  function automatic logic [MIDX_W-1:0] gest_measure(input logic [3:0] g);
    logic [MIDX_W-1:0] r;
    begin
      case (g)
        4'd0: r = 3'd0;
        4'd1, 4'd2: r = 3'd1;
        4'd3, 4'd4: r = 3'd2;
        4'd5, 4'd6: r = 3'd3;
        4'd7: r = 3'd4;
        4'd8: r = 3'd5;
        4'd9: r = 3'd6;
        4'd10: r = 3'd7;
        default: r = 3'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic gest_neg(input logic [3:0] g);
    logic r;
    begin
      case (g)
        4'd1, 4'd4, 4'd5, 4'd9, 4'd10: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

endpackage

### hdl/face_gesture_classifier.sv
// ----------------------------------------------------------------------------
// face_gesture_classifier
// Hysteresis and debounce gesture detector with EMA baselines.
// Per frame: the input word is loaded, then the alpha divider runs (2 bits
// a cycle), an evaluate step checks the channels and a tracking step per
// measure follows before out_tvalid; one frame at a time, so a new word is
// taken only after out_tready has taken the result.
// Reset: rst_n synchronous active low, clears registers to defaults and state.
// ----------------------------------------------------------------------------
module face_gesture_classifier #(
  parameter int MEASURE_WIDTH = fgc_pkg::MEASURE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: time_stamp, measure_brow, yaw, pitch, roll, mouth, smile, eye_left, eye_right
  input  logic [((32 + 8*MEASURE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // tuser: face_found
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: gesture_mask
  output logic [15:0] out_tdata,
  input  logic cfg_wr_en,
  input  logic [fgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fgc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  fgc_pkg::cmd_t cmd;
  fgc_pkg::sts_t sts;
  logic in_fire;
  logic [fgc_pkg::NUM_GESTURES-1:0] mask;

  assign in_fire = in_tvalid && in_tready;

  fgc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  fgc_datapath #(.MEASURE_WIDTH(MEASURE_WIDTH)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .face_found   (in_tuser),
    .time_stamp   (in_tdata[31:0]),
    .measures     (in_tdata[32 +: 8*MEASURE_WIDTH]),
    .gesture_mask (mask)
  );

  assign out_tdata = {5'd0, mask};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("controller did not start");
`endif

endmodule

### hdl/fgc_ctrl.sv
// ----------------------------------------------------------------------------
// fgc_ctrl
// Frame sequencer: load, alpha division, channel update, baseline tracking.
// ----------------------------------------------------------------------------
module fgc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_tready,
  input  fgc_pkg::sts_t    sts,
  output fgc_pkg::cmd_t    cmd,
  output logic             in_tready,
  output logic             out_tvalid
);

  fgc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fgc_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fgc_pkg::ST_IDLE:  if (in_fire) state_nxt = fgc_pkg::ST_DIV;
      fgc_pkg::ST_DIV:   if (sts.div_done) state_nxt = fgc_pkg::ST_EVAL;
      fgc_pkg::ST_EVAL:  state_nxt = fgc_pkg::ST_TRACK;
      fgc_pkg::ST_TRACK: if (sts.track_done) state_nxt = fgc_pkg::ST_OUT;
      fgc_pkg::ST_OUT:   if (out_tready) state_nxt = fgc_pkg::ST_IDLE;
      default:           state_nxt = fgc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      fgc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load = in_fire;
        cmd.div_start = in_fire;
      end
      fgc_pkg::ST_EVAL:  cmd.eval = 1'b1;
      fgc_pkg::ST_TRACK: cmd.track = 1'b1;
      fgc_pkg::ST_OUT:   out_tvalid = 1'b1;
      default: ;
    endcase
  end

endmodule

### hdl/fgc_div.sv
// ----------------------------------------------------------------------------
// fgc_div
// Restoring divider for alpha = floor(dt * 65536 / baseline_ticks), 2 bits a cycle.
// ----------------------------------------------------------------------------
module fgc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dt,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [16:0] alpha
);

  logic [47:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [15:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        sat_r, sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  always_comb begin
    logic [32:0] r;
    logic [47:0] n;
    logic [15:0] q;
    r = rem_r;
    n = num_r;
    q = q_r;
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    sat_nxt = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      sat_nxt = (divisor == 32'd0) || (dt >= divisor);
      r = '0;
      n = {dt, 16'd0};
      q = '0;
    end else if (busy_r) begin
      for (int k = 0; k < 2; k++) begin
        r = {r[31:0], n[47]};
        n = {n[46:0], 1'b0};
        if (r >= {1'b0, divisor}) begin
          r = r - {1'b0, divisor};
          q = {q[14:0], 1'b1};
        end else begin
          q = {q[14:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) busy_nxt = 1'b0;
    end
    rem_nxt = r;
    num_nxt = n;
    q_nxt = q;
  end

  // quotient bits 16 and above are zero when not saturated; saturated alpha is 65536
  assign done  = busy_r && (cnt_r == 5'd23) ? 1'b0 : (!busy_r && cnt_r == 5'd24);
  assign alpha = sat_r ? 17'h10000 : {1'b0, q_r};

endmodule

### hdl/fgc_datapath.sv
// ----------------------------------------------------------------------------
// fgc_datapath
// Registers, frame fields, channel debounce and baseline EMA, one measure a cycle.
// ----------------------------------------------------------------------------
module fgc_datapath #(
  parameter int MEASURE_WIDTH = fgc_pkg::MEASURE_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  fgc_pkg::cmd_t                         cmd,
  output fgc_pkg::sts_t                         sts,
  input  logic                                  cfg_wr_en,
  input  logic [fgc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fgc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  face_found,
  input  logic [31:0]                           time_stamp,
  input  logic [fgc_pkg::NUM_MEASURES*MEASURE_WIDTH-1:0] measures,
  output logic [fgc_pkg::NUM_GESTURES-1:0]      gesture_mask
);

  localparam int MW = MEASURE_WIDTH;
  localparam int DW = MW + 1;
  // compare width: holds the deviation and a 16-bit level with a sign bit
  localparam int EW = (DW + 1 > 18) ? DW + 1 : 18;
  localparam int NM = fgc_pkg::NUM_MEASURES;
  localparam int NG = fgc_pkg::NUM_GESTURES;

  logic [63:0] thr_head_r;
  logic [47:0] thr_face_r;
  logic [15:0] rel_frac_r;
  logic [7:0]  debounce_r;
  logic [31:0] bl_ticks_r;
  logic [31:0] noface_r;

  logic signed [MW-1:0] baseline_r [NM];
  logic signed [MW-1:0] meas_r [NM];
  logic        bl_valid_r;
  logic [31:0] prev_time_r;
  logic [31:0] last_face_r;
  logic        seen_r;
  logic        face_r;
  logic [31:0] dt_r;
  logic [NG-1:0] active_r;
  logic [fgc_pkg::CNT_W-1:0] count_r [NG];
  logic [NM-1:0] frozen_r;
  logic [fgc_pkg::MIDX_W:0] trk_r;
  logic        trk_en_r;

  logic        div_done;
  logic [16:0] alpha;
  logic [31:0] dt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_head_r <= '0;
      thr_face_r <= '0;
      rel_frac_r <= 16'd32768;
      debounce_r <= 8'd3;
      bl_ticks_r <= 32'd1000;
      noface_r   <= 32'd1000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fgc_pkg::REG_THR_HEAD: thr_head_r <= cfg_wdata;
        fgc_pkg::REG_THR_FACE: thr_face_r <= cfg_wdata[47:0];
        fgc_pkg::REG_RELEASE:  rel_frac_r <= cfg_wdata[15:0];
        fgc_pkg::REG_DEBOUNCE: debounce_r <= cfg_wdata[7:0];
        fgc_pkg::REG_BL_TICKS: bl_ticks_r <= cfg_wdata[31:0];
        fgc_pkg::REG_NOFACE:   noface_r   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign dt_nxt = bl_valid_r ? (time_stamp - prev_time_r) : 32'd0;

  fgc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dt      (dt_nxt),
    .divisor (bl_ticks_r),
    .done    (div_done),
    .alpha   (alpha)
  );

  // set and release levels per measure
  logic [15:0] set_lv [NM];
  logic [15:0] rel_lv [NM];
  always_comb begin
    logic [31:0] p;
    for (int i = 0; i < NM; i++) begin
      if (i < 4) set_lv[i] = thr_head_r[16*i +: 16];
      else if (i < 6) set_lv[i] = thr_face_r[16*(i-4) +: 16];
      else set_lv[i] = thr_face_r[47:32];
      p = set_lv[i] * rel_frac_r;
      rel_lv[i] = p[31:16];
    end
  end

  // evaluation of all channels on the loaded frame
  logic [NG-1:0] raw;
  logic [NG-1:0] act_new;
  logic [fgc_pkg::CNT_W-1:0] cnt_new [NG];
  logic [NM-1:0] frz_new;
  logic signed [EW-1:0] eye_l, eye_r;
  always_comb begin
    logic [fgc_pkg::MIDX_W-1:0] mi;
    logic signed [EW-1:0] dev;
    logic [15:0] lvl;
    logic [fgc_pkg::CNT_W-1:0] c;
    frz_new = '0;
    for (int g = 0; g < NG; g++) begin
      mi  = fgc_pkg::gest_measure(4'(g));
      dev = EW'(meas_r[mi]) - EW'(baseline_r[mi]);
      if (fgc_pkg::gest_neg(4'(g))) dev = -dev;
      lvl = active_r[g] ? rel_lv[mi] : set_lv[mi];
      raw[g] = dev > $signed({{(EW-16){1'b0}}, lvl});
    end
    eye_l = EW'(baseline_r[fgc_pkg::LEFT_EYE]) - EW'(meas_r[fgc_pkg::LEFT_EYE]);
    eye_r = EW'(baseline_r[fgc_pkg::RIGHT_EYE]) - EW'(meas_r[fgc_pkg::RIGHT_EYE]);
    if (eye_r > $signed({{(EW-16){1'b0}}, rel_lv[fgc_pkg::LEFT_EYE]}))
      raw[fgc_pkg::WINK_L] = 1'b0;
    if (eye_l > $signed({{(EW-16){1'b0}}, rel_lv[fgc_pkg::LEFT_EYE]}))
      raw[fgc_pkg::WINK_R] = 1'b0;
    for (int g = 0; g < NG; g++) begin
      act_new[g] = active_r[g];
      c = '0;
      if (raw[g] != active_r[g]) begin
        c = count_r[g] + 8'd1;
        if (c >= debounce_r) begin
          act_new[g] = raw[g];
          c = '0;
        end
      end
      cnt_new[g] = c;
      if (act_new[g] || c != '0) frz_new[fgc_pkg::gest_measure(4'(g))] = 1'b1;
    end
  end

  // EMA on one measure per cycle
  logic [fgc_pkg::MIDX_W-1:0] ti;
  logic signed [MW-1:0] bl_upd;
  logic signed [DW-1:0] diff;
  logic signed [DW+17:0] prod;
  logic [DW+17:0] mag;
  assign ti = trk_r[fgc_pkg::MIDX_W-1:0];
  always_comb begin
    diff = DW'(meas_r[ti]) - DW'(baseline_r[ti]);
    prod = (DW+18)'(diff) * $signed({1'b0, alpha});
    if (prod >= 0) begin
      mag = (DW+18)'((prod + 32768) >>> 16);
      bl_upd = MW'(baseline_r[ti] + mag[MW-1:0]);
    end else begin
      mag = (DW+18)'((-prod + 32768) >>> 16);
      bl_upd = MW'(baseline_r[ti] - mag[MW-1:0]);
    end
  end

  assign sts.div_done   = div_done;
  assign sts.track_done = (trk_r == (fgc_pkg::MIDX_W+1)'(NM - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bl_valid_r  <= 1'b0;
      prev_time_r <= '0;
      last_face_r <= '0;
      seen_r      <= 1'b0;
      active_r    <= '0;
      trk_r       <= '0;
      trk_en_r    <= 1'b0;
      for (int g = 0; g < NG; g++) count_r[g] <= '0;
      for (int i = 0; i < NM; i++) baseline_r[i] <= '0;
    end else begin
      if (cmd.load) begin
        face_r <= face_found;
        dt_r <= dt_nxt;
        prev_time_r <= time_stamp;
        for (int i = 0; i < NM; i++) meas_r[i] <= measures[i*MW +: MW];
        if (!face_found) begin
          if (!seen_r || $signed(time_stamp - last_face_r) > $signed({1'b0, noface_r})) begin
            active_r <= '0;
            for (int g = 0; g < NG; g++) count_r[g] <= '0;
          end
        end else begin
          last_face_r <= time_stamp;
          seen_r <= 1'b1;
          if (!bl_valid_r) begin
            bl_valid_r <= 1'b1;
            for (int i = 0; i < NM; i++) baseline_r[i] <= measures[i*MW +: MW];
          end
        end
      end
      if (cmd.eval && face_r) begin
        active_r <= act_new;
        for (int g = 0; g < NG; g++) count_r[g] <= cnt_new[g];
        frozen_r <= frz_new;
      end
      if (cmd.eval) begin
        trk_r <= '0;
        trk_en_r <= face_r && ($signed(dt_r) > 0);
      end
      if (cmd.track) begin
        if (trk_en_r && !frozen_r[ti]) baseline_r[ti] <= bl_upd;
        trk_r <= trk_r + 1'b1;
      end
    end
  end

  assign gesture_mask = active_r;

endmodule
